FILE: rtl/core/rsm_pkg.sv
// Shared types and constants for the rotary speaker modulation block.
`timescale 1ns / 1ps

package rsm_pkg;

    // Sequencer steps; most of them issue a product to the shared multiplier
    typedef enum logic [4:0] {
        S_IDLE,
        S_SIN0,
        S_SIN1,
        S_SIN2,
        S_SIN3,
        S_SIN4,
        S_DA,
        S_DB,
        S_TA,
        S_TB0,
        S_TB1,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_M6,
        S_M7,
        S_M8,
        S_OUT
    } state_t;

    // Configuration register indexes
    localparam logic [2:0] REG_PHASE_STEP  = 3'd0;
    localparam logic [2:0] REG_MIN_DELAY   = 3'd1;
    localparam logic [2:0] REG_DELAY_DEPTH = 3'd2;
    localparam logic [2:0] REG_DRY_GAIN    = 3'd3;
    localparam logic [2:0] REG_WET_GAIN    = 3'd4;

    // Register reset values
    localparam logic [31:0] PHASE_STEP_RST  = 32'd35791;
    localparam logic [19:0] MIN_DELAY_RST   = 20'd86016;
    localparam logic [19:0] DELAY_DEPTH_RST = 20'd6144;
    localparam logic [15:0] DRY_GAIN_RST    = 16'd0;
    localparam logic [15:0] WET_GAIN_RST    = 16'd32768;

    // LFO phase after reset: one radian
    localparam logic [31:0] PHASE_RST = 32'd683565276;

    // Quarter-wave sine polynomial coefficients, Q16
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [16:0] SIN_B = 17'd42334;
    localparam logic [16:0] SIN_C = 17'd4926;

    // Cross-mix weight 0.7 in Q15
    localparam logic [14:0] CROSS_WEIGHT = 15'd22938;

endpackage

FILE: rtl/core/rotary_speaker_modulation.sv
// Rotary speaker modulation: one shared multiplier stepped by a small sequencer.
// Each item runs through the sine, delay tap, mix and output steps, and a new one is
// accepted only back in idle, after the output step has handed over the result; the 16
// products share the single multiplier and the four reads share the one delay line port.
// Reset (rst_n, asynchronous, active low) restores registers, phase, pointer and
// tap history; unwritten delay line slots read as zero through a fill flag.
`timescale 1ns / 1ps

module rotary_speaker_modulation #(
    parameter int LINE_DEPTH       = 4096,
    parameter int SAMPLE_BITS      = 24,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    input  logic                          wr_en,
    input  logic [2:0]                    wr_index,
    input  logic [31:0]                   wr_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int LA  = $clog2(LINE_DEPTH);
    localparam int TB  = $clog2(SINE_TABLE_DEPTH);
    localparam int AW  = (SB + 3 > 21) ? SB + 3 : 21;
    localparam int BW  = 18;
    localparam int PW  = AW + BW;
    localparam int SW  = PW + 1;
    localparam int DLW = 22;

    localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - TB)) - 32'd1);
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [SB-1:0] sat_s(input logic signed [SW-1:0] x);
        logic signed [SB-1:0] r;
        if (x > SAT_HI)
        begin
            r = SAT_HI[SB-1:0];
        end
        else if (x < SAT_LO)
        begin
            r = SAT_LO[SB-1:0];
        end
        else
        begin
            r = x[SB-1:0];
        end
        return r;
    endfunction

    // Configuration
    logic [31:0] phase_step_reg;
    logic [19:0] min_delay_reg;
    logic [19:0] delay_depth_reg;
    logic [15:0] dry_gain_reg;
    logic [15:0] wet_gain_reg;

    // Control and architectural state
    rsm_pkg::state_t       state_reg, state_next;
    logic [31:0]           phase_reg, phase_next;
    logic [LA-1:0]         wp_reg, wp_next;
    logic                  full_reg, full_next;
    logic signed [SB-1:0]  prev_a_reg, prev_a_next;
    logic signed [SB-1:0]  prev_b_reg, prev_b_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  rd_ok_reg, rd_ok_next;

    // Working registers
    logic signed [SB-1:0]  l_reg, l_next;
    logic signed [SB-1:0]  r_reg, r_next;
    logic signed [SB-1:0]  avg_reg, avg_next;
    logic [16:0]           u2_reg, u2_next;
    logic [15:0]           lga_reg, lga_next;
    logic [15:0]           lgb_reg, lgb_next;
    logic [DLW-1:0]        da_reg, da_next;
    logic [DLW-1:0]        db_reg, db_next;
    logic signed [SB+1:0]  ta_reg, ta_next;
    logic signed [SB+1:0]  tb_reg, tb_next;
    logic signed [SB+2:0]  mixl_reg, mixl_next;
    logic signed [SB+2:0]  mixr_reg, mixr_next;
    logic signed [PW-1:0]  acc_reg, acc_next;
    logic signed [SB-1:0]  lres_reg, lres_next;
    logic signed [SB-1:0]  rres_reg, rres_next;
    logic signed [SB-1:0]  lout_reg, lout_next;
    logic signed [SB-1:0]  rout_reg, rout_next;

    // Shared multiplier and delay line
    logic signed [AW-1:0]  mul_a;
    logic signed [BW-1:0]  mul_b;
    logic signed [PW-1:0]  prod;
    logic                  line_we;
    logic [LA-1:0]         rd_addr;
    logic [SB-1:0]         rdata;

    rsm_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    rsm_line #(
        .DEPTH (LINE_DEPTH),
        .WIDTH (SB)
    ) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (wp_reg),
        .wdata (avg_reg),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // Sine argument from the quantised phase
    logic [31:0]          p_q;
    logic [1:0]           quad;
    logic [16:0]          u_w;
    logic [16:0]          s17;
    logic [15:0]          s16;
    logic [16:0]          lfo_w;
    logic signed [SB-1:0] x_cur;

    assign p_q   = phase_reg & PHASE_MASK;
    assign quad  = p_q[31:30];
    assign u_w   = quad[0] ? (17'd65536 - {1'b0, p_q[29:14]}) : {1'b0, p_q[29:14]};
    assign s17   = prod[33:17];
    assign s16   = (s17 > 17'd32767) ? 16'd32767 : s17[15:0];
    assign lfo_w = quad[1] ? (17'd0 - {1'b0, s16}) : {1'b0, s16};
    // Slots not yet written read as zero
    assign x_cur = rd_ok_reg ? $signed(rdata) : '0;

    assign in_ready  = (state_reg == rsm_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign left_out  = lout_reg;
    assign right_out = rout_reg;

    always_comb
    begin
        logic [DLW-1:0]       dly;
        logic [16:0]          tv;
        logic signed [SB+1:0] ysum;
        logic signed [SW-1:0] osum;

        state_next     = state_reg;
        phase_next     = phase_reg;
        wp_next        = wp_reg;
        full_next      = full_reg;
        prev_a_next    = prev_a_reg;
        prev_b_next    = prev_b_reg;
        out_valid_next = out_valid_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        avg_next       = avg_reg;
        u2_next        = u2_reg;
        lga_next       = lga_reg;
        lgb_next       = lgb_reg;
        da_next        = da_reg;
        db_next        = db_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        mixl_next      = mixl_reg;
        mixr_next      = mixr_reg;
        acc_next       = acc_reg;
        lres_next      = lres_reg;
        rres_next      = rres_reg;
        lout_next      = lout_reg;
        rout_next      = rout_reg;
        mul_a          = '0;
        mul_b          = '0;
        line_we        = 1'b0;
        rd_addr        = wp_reg;
        dly            = DLW'(prod[35:16]) + DLW'(min_delay_reg) + DLW'(9'd256);
        tv             = '0;
        ysum           = (SB+2)'($signed(prod[SB+8:8])) + (SB+2)'(x_cur);
        osum           = (SW'(acc_reg) + SW'(prod)) >>> 16;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rsm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    l_next     = left_in;
                    r_next     = right_in;
                    avg_next   = SB'(((SB+1)'(left_in) + (SB+1)'(right_in)) >>> 1);
                    phase_next = phase_reg + phase_step_reg;
                    state_next = rsm_pkg::S_SIN0;
                end
            end
            rsm_pkg::S_SIN0:
            begin
                mul_a      = AW'(u_w);
                mul_b      = BW'(u_w);
                state_next = rsm_pkg::S_SIN1;
            end
            rsm_pkg::S_SIN1:
            begin
                u2_next    = prod[32:16];
                mul_a      = AW'(prod[32:16]);
                mul_b      = BW'(rsm_pkg::SIN_C);
                state_next = rsm_pkg::S_SIN2;
            end
            rsm_pkg::S_SIN2:
            begin
                tv         = rsm_pkg::SIN_B - prod[32:16];
                mul_a      = AW'(u2_reg);
                mul_b      = BW'(tv);
                state_next = rsm_pkg::S_SIN3;
            end
            rsm_pkg::S_SIN3:
            begin
                tv         = rsm_pkg::SIN_A - prod[32:16];
                mul_a      = AW'(u_w);
                mul_b      = BW'(tv);
                state_next = rsm_pkg::S_SIN4;
            end
            rsm_pkg::S_SIN4:
            begin
                // Tremolo gains double as the delay swing factors
                lga_next   = 16'(17'd32768 + lfo_w);
                lgb_next   = 16'(17'd32768 - lfo_w);
                mul_a      = AW'(delay_depth_reg);
                mul_b      = BW'(16'(17'd32768 + lfo_w));
                state_next = rsm_pkg::S_DA;
            end
            rsm_pkg::S_DA:
            begin
                da_next    = dly;
                rd_addr    = wp_reg + LA'(dly[DLW-1:8]);
                mul_a      = AW'(delay_depth_reg);
                mul_b      = BW'(lgb_reg);
                state_next = rsm_pkg::S_DB;
            end
            rsm_pkg::S_DB:
            begin
                db_next    = dly;
                rd_addr    = wp_reg + LA'(da_reg[DLW-1:8]) + LA'(1);
                mul_a      = AW'((SB+1)'(x_cur) - (SB+1)'(prev_a_reg));
                mul_b      = BW'(9'd256 - {1'b0, da_reg[7:0]});
                state_next = rsm_pkg::S_TA;
            end
            rsm_pkg::S_TA:
            begin
                prev_a_next = sat_s(SW'(ysum));
                rd_addr     = wp_reg + LA'(db_reg[DLW-1:8]);
                state_next  = rsm_pkg::S_TB0;
            end
            rsm_pkg::S_TB0:
            begin
                rd_addr    = wp_reg + LA'(db_reg[DLW-1:8]) + LA'(1);
                mul_a      = AW'((SB+1)'(x_cur) - (SB+1)'(prev_b_reg));
                mul_b      = BW'(9'd256 - {1'b0, db_reg[7:0]});
                state_next = rsm_pkg::S_TB1;
            end
            rsm_pkg::S_TB1:
            begin
                prev_b_next = sat_s(SW'(ysum));
                // All taps read: store the new sample and advance the pointer
                line_we     = 1'b1;
                wp_next     = wp_reg - LA'(1);
                if (wp_reg == '0)
                begin
                    full_next = 1'b1;
                end
                mul_a       = AW'(prev_a_reg);
                mul_b       = BW'(lga_reg);
                state_next  = rsm_pkg::S_M1;
            end
            rsm_pkg::S_M1:
            begin
                ta_next    = $signed(prod[SB+16:15]);
                mul_a      = AW'(prev_b_reg);
                mul_b      = BW'(lgb_reg);
                state_next = rsm_pkg::S_M2;
            end
            rsm_pkg::S_M2:
            begin
                tb_next    = $signed(prod[SB+16:15]);
                mul_a      = AW'($signed(prod[SB+16:15]));
                mul_b      = BW'(rsm_pkg::CROSS_WEIGHT);
                state_next = rsm_pkg::S_M3;
            end
            rsm_pkg::S_M3:
            begin
                mixl_next  = (SB+3)'(ta_reg) + (SB+3)'($signed(prod[SB+16:15]));
                mul_a      = AW'(ta_reg);
                mul_b      = BW'(rsm_pkg::CROSS_WEIGHT);
                state_next = rsm_pkg::S_M4;
            end
            rsm_pkg::S_M4:
            begin
                mixr_next  = (SB+3)'(tb_reg) + (SB+3)'($signed(prod[SB+16:15]));
                mul_a      = AW'(l_reg);
                mul_b      = BW'({dry_gain_reg, 1'b0});
                state_next = rsm_pkg::S_M5;
            end
            rsm_pkg::S_M5:
            begin
                acc_next   = prod;
                mul_a      = AW'(mixl_reg);
                mul_b      = BW'(wet_gain_reg);
                state_next = rsm_pkg::S_M6;
            end
            rsm_pkg::S_M6:
            begin
                lres_next  = sat_s(osum);
                mul_a      = AW'(r_reg);
                mul_b      = BW'({dry_gain_reg, 1'b0});
                state_next = rsm_pkg::S_M7;
            end
            rsm_pkg::S_M7:
            begin
                acc_next   = prod;
                mul_a      = AW'(mixr_reg);
                mul_b      = BW'(wet_gain_reg);
                state_next = rsm_pkg::S_M8;
            end
            rsm_pkg::S_M8:
            begin
                rres_next  = sat_s(osum);
                state_next = rsm_pkg::S_OUT;
            end
            rsm_pkg::S_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    lout_next      = lres_reg;
                    rout_next      = rres_reg;
                    out_valid_next = 1'b1;
                    state_next     = rsm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rsm_pkg::S_IDLE;
            end
        endcase

        rd_ok_next = full_reg || (rd_addr > wp_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= rsm_pkg::PHASE_STEP_RST;
            min_delay_reg   <= rsm_pkg::MIN_DELAY_RST;
            delay_depth_reg <= rsm_pkg::DELAY_DEPTH_RST;
            dry_gain_reg    <= rsm_pkg::DRY_GAIN_RST;
            wet_gain_reg    <= rsm_pkg::WET_GAIN_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                rsm_pkg::REG_PHASE_STEP:  phase_step_reg  <= wr_data;
                rsm_pkg::REG_MIN_DELAY:   min_delay_reg   <= wr_data[19:0];
                rsm_pkg::REG_DELAY_DEPTH: delay_depth_reg <= wr_data[19:0];
                rsm_pkg::REG_DRY_GAIN:    dry_gain_reg    <= wr_data[15:0];
                rsm_pkg::REG_WET_GAIN:    wet_gain_reg    <= wr_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsm_pkg::S_IDLE;
            phase_reg     <= rsm_pkg::PHASE_RST;
            wp_reg        <= '1;
            full_reg      <= 1'b0;
            prev_a_reg    <= '0;
            prev_b_reg    <= '0;
            out_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            wp_reg        <= wp_next;
            full_reg      <= full_next;
            prev_a_reg    <= prev_a_next;
            prev_b_reg    <= prev_b_next;
            out_valid_reg <= out_valid_next;
            rd_ok_reg     <= rd_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg    <= l_next;
        r_reg    <= r_next;
        avg_reg  <= avg_next;
        u2_reg   <= u2_next;
        lga_reg  <= lga_next;
        lgb_reg  <= lgb_next;
        da_reg   <= da_next;
        db_reg   <= db_next;
        ta_reg   <= ta_next;
        tb_reg   <= tb_next;
        mixl_reg <= mixl_next;
        mixr_reg <= mixr_next;
        acc_reg  <= acc_next;
        lres_reg <= lres_next;
        rres_reg <= rres_next;
        lout_reg <= lout_next;
        rout_reg <= rout_next;
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == rsm_pkg::S_SIN0))
        else $error("accepted item did not start the sine step");

    a_wp_moves_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != rsm_pkg::S_TB1) |=> $stable(wp_reg))
        else $error("write pointer moved outside the line write step");

    a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("fill flag cleared without reset");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == rsm_pkg::S_OUT))
        else $error("result presented outside the output step");
`endif

endmodule

FILE: rtl/core/rsm_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module rsm_mul #(
    parameter int AW = 27,
    parameter int BW = 18
) (
    input  logic                    clk,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    logic signed [AW+BW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

FILE: rtl/core/rsm_line.sv
// Circular delay line storage: one write port, one registered read port.
`timescale 1ns / 1ps

module rsm_line #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
